@@ src/trf_pkg.sv @@
// Shared types and constants of the threshold region finder.
`timescale 1ns / 1ps

package trf_pkg;

	localparam int MAX_SEQ_LEN = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int POS_W       = $clog2(MAX_SEQ_LEN) + 1;

	localparam int THR_W   = 16;
	localparam int START_W = 12;
	localparam int LEN_W   = 13;
	localparam int CNT_W   = 12;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 16;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [CIDX_W-1:0] {
		CFG_LEVEL_THRESHOLD  = 2'd0,
		CFG_MIN_RUN_LENGTH   = 2'd1,
		CFG_MAX_RUN_LENGTH   = 2'd2,
		CFG_MIN_REGION_COUNT = 2'd3
	} cfg_idx_t;

	localparam logic KIND_REGION  = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef struct packed {
		logic signed [THR_W-1:0] level_threshold;
		logic [LEN_W-1:0]        min_run_length;
		logic [LEN_W-1:0]        max_run_length;
		logic [CNT_W-1:0]        min_region_count;
	} cfg_t;

	// One classified sample as it travels through the queue.
	typedef struct packed {
		logic above;
		logic eos;
	} class_t;

	typedef struct packed {
		logic               kind;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
		logic [START_W-1:0] offset;
		logic [CNT_W-1:0]   count;
		logic               enough;
		logic               too_long;
		logic               last;
	} result_t;

endpackage

@@ src/threshold_region_finder_top.sv @@
// Top level of the threshold region finder: configuration registers and wiring.
`timescale 1ns / 1ps

// Takes one signed Q8.8 sample per cycle while in_ready is high and reports
// each maximal run at or above level_threshold whose length lies within
// [min_run_length, max_run_length], followed by a verdict at the end of each
// sequence. The front end compares the sample and pushes its class into a
// four-entry queue in the same cycle; the back end drains one queue entry per
// cycle into a single output register unless out_ready or a verdict stalls it.
// Sustained rate is one sample per cycle unless the output stalls; an
// end-of-sequence sample that also closes a reported region yields two results
// in turn in the output register, which the queue absorbs. Configuration
// writes are taken every cycle and should be made only while the block is idle.
module threshold_region_finder_top import trf_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CIDX_W-1:0]             cfg_index,
	input  logic [CDATA_W-1:0]            cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          end_of_sequence,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          result_kind,
	output logic [START_W-1:0]            region_start,
	output logic [LEN_W-1:0]              region_length,
	output logic [START_W-1:0]            region_offset,
	output logic [CNT_W-1:0]              region_count,
	output logic                          enough_regions,
	output logic                          too_long,
	output logic                          last_result
);

	cfg_t    cfg_q;
	logic    head_valid;
	class_t  head;
	logic    pop;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_threshold  <= '0;
			cfg_q.min_run_length   <= LEN_W'(1);
			cfg_q.max_run_length   <= LEN_W'(MAX_SEQ_LEN);
			cfg_q.min_region_count <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LEVEL_THRESHOLD:  cfg_q.level_threshold  <= cfg_data[THR_W-1:0];
				CFG_MIN_RUN_LENGTH:   cfg_q.min_run_length   <= cfg_data[LEN_W-1:0];
				CFG_MAX_RUN_LENGTH:   cfg_q.max_run_length   <= cfg_data[LEN_W-1:0];
				CFG_MIN_REGION_COUNT: cfg_q.min_region_count <= cfg_data[CNT_W-1:0];
				default:              cfg_q <= cfg_q;
			endcase
		end
	end

	trf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample          (sample),
		.end_of_sequence (end_of_sequence),
		.level_threshold (cfg_q.level_threshold),
		.pop             (pop),
		.head_valid      (head_valid),
		.head            (head)
	);

	trf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign result_kind    = res.kind;
	assign region_start   = res.start;
	assign region_length  = res.length;
	assign region_offset  = res.offset;
	assign region_count   = res.count;
	assign enough_regions = res.enough;
	assign too_long       = res.too_long;
	assign last_result    = res.last;

endmodule

@@ src/trf_front.sv @@
// Front end: accepts samples, compares against the threshold, queues the class.
`timescale 1ns / 1ps

module trf_front import trf_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          end_of_sequence,
	input  logic signed [THR_W-1:0]       level_threshold,
	input  logic                          pop,
	output logic                          head_valid,
	output class_t                        head
);

	class_t            queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              do_pop;
	class_t            cls;

	assign in_ready   = (count_q != QCNT_W'(QDEPTH));
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = queue_q[rd_ptr_q];

	always_comb begin
		cls.above = (sample >= level_threshold);
		cls.eos   = end_of_sequence;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/trf_back.sv @@
// Back end: run tracking, region reports, verdicts and the output register.
`timescale 1ns / 1ps

module trf_back import trf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    head_valid,
	input  class_t  head,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res
);

	logic [POS_W-1:0]   position_q;
	logic               in_run_q;
	logic [START_W-1:0] run_start_q;
	logic [LEN_W-1:0]   run_length_q;
	logic [START_W-1:0] first_start_q;
	logic [CNT_W-1:0]   regions_q;
	logic               overflowed_q;
	logic               verdict_pending_q;
	logic               out_valid_q;
	result_t            res_q;

	logic               advance;
	logic               valid_pos;
	logic               s_in_run;
	logic [START_W-1:0] s_start;
	logic [LEN_W-1:0]   s_len;
	logic               s_ovf;
	logic               closing;
	logic               report;
	logic [START_W-1:0] n_first;
	logic [START_W-1:0] n_offset;
	logic [CNT_W-1:0]   n_regions;

	assign advance   = !out_valid_q || out_ready;
	assign pop       = advance && !verdict_pending_q && head_valid;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		valid_pos = (position_q < POS_W'(MAX_SEQ_LEN));
		s_in_run  = in_run_q;
		s_start   = run_start_q;
		s_len     = run_length_q;
		s_ovf     = overflowed_q || !valid_pos;
		if (valid_pos && head.above) begin
			if (!in_run_q) begin
				s_in_run = 1'b1;
				s_start  = position_q[START_W-1:0];
				s_len    = LEN_W'(1);
			end else begin
				s_len = run_length_q + 1'b1;
			end
		end
		// A sample below threshold and the sequence end both close the same run.
		closing = (valid_pos && !head.above) || head.eos;
		report  = closing && s_in_run && (s_len != '0) &&
			(s_len >= cfg.min_run_length) && (s_len <= cfg.max_run_length);
		n_first   = first_start_q;
		n_offset  = '0;
		n_regions = regions_q;
		if (report) begin
			if (regions_q == '0) begin
				n_first = s_start;
			end else begin
				n_offset = s_start - first_start_q;
			end
			if (regions_q != COUNT_MAX) begin
				n_regions = regions_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (verdict_pending_q) begin
				res_q <= '{kind: KIND_VERDICT, start: '0, length: '0, offset: '0,
					count: regions_q, enough: (regions_q >= cfg.min_region_count),
					too_long: overflowed_q, last: 1'b1};
			end else if (report) begin
				// Hold back the last mark when a verdict follows.
				res_q <= '{kind: KIND_REGION, start: s_start, length: s_len,
					offset: n_offset, count: n_regions, enough: 1'b0,
					too_long: 1'b0, last: !head.eos};
			end else begin
				res_q <= '{kind: KIND_VERDICT, start: '0, length: '0, offset: '0,
					count: n_regions, enough: (n_regions >= cfg.min_region_count),
					too_long: s_ovf, last: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q        <= '0;
			in_run_q          <= 1'b0;
			run_start_q       <= '0;
			run_length_q      <= '0;
			first_start_q     <= '0;
			regions_q         <= '0;
			overflowed_q      <= 1'b0;
			verdict_pending_q <= 1'b0;
			out_valid_q       <= 1'b0;
		end else if (advance) begin
			if (verdict_pending_q) begin
				out_valid_q       <= 1'b1;
				verdict_pending_q <= 1'b0;
				position_q        <= '0;
				first_start_q     <= '0;
				regions_q         <= '0;
				overflowed_q      <= 1'b0;
			end else if (head_valid) begin
				out_valid_q <= report || head.eos;
				if (head.eos && !report) begin
					position_q    <= '0;
					in_run_q      <= 1'b0;
					run_start_q   <= '0;
					run_length_q  <= '0;
					first_start_q <= '0;
					regions_q     <= '0;
					overflowed_q  <= 1'b0;
				end else begin
					verdict_pending_q <= head.eos;
					if (valid_pos) begin
						position_q <= position_q + 1'b1;
					end
					overflowed_q  <= s_ovf;
					first_start_q <= n_first;
					regions_q     <= n_regions;
					if (closing) begin
						in_run_q     <= 1'b0;
						run_start_q  <= '0;
						run_length_q <= '0;
					end else begin
						in_run_q     <= s_in_run;
						run_start_q  <= s_start;
						run_length_q <= s_len;
					end
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/trf_checker.sv @@
// Port-level checker for the threshold region finder, bound to the top level.
`timescale 1ns / 1ps

module trf_checker import trf_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               result_kind,
	input logic [START_W-1:0] region_start,
	input logic [LEN_W-1:0]   region_length,
	input logic [START_W-1:0] region_offset,
	input logic               enough_regions,
	input logic               too_long,
	input logic               last_result
);

	// A stalled result transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(result_kind) && $stable(region_start) &&
			 $stable(region_length) && $stable(last_result)))
		else $error("result changed while stalled");

	a_verdict_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_VERDICT) |->
			(region_start == '0 && region_length == '0 && region_offset == '0 &&
			 last_result))
		else $error("verdict carries region fields or lacks last mark");

	a_report_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_REGION) |->
			(region_length != '0 && !enough_regions && !too_long &&
			 region_offset <= region_start))
		else $error("malformed region report");

	// A report not marked last is followed directly by its verdict.
	a_report_then_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && result_kind == KIND_REGION && !last_result) |=>
			(out_valid && result_kind == KIND_VERDICT))
		else $error("verdict did not follow report");

endmodule

bind threshold_region_finder_top trf_checker u_trf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.result_kind    (result_kind),
	.region_start   (region_start),
	.region_length  (region_length),
	.region_offset  (region_offset),
	.enough_regions (enough_regions),
	.too_long       (too_long),
	.last_result    (last_result)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the threshold region finder with a built-in predictor.
`timescale 1ns / 1ps

module testbench;
	import trf_pkg::*;

	typedef struct {
		logic [SAMPLE_BITS-1:0] value;
		logic                   eos;
	} sample_item_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CIDX_W-1:0]             cfg_index = '0;
	logic [CDATA_W-1:0]            cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic                          end_of_sequence = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          result_kind;
	logic [START_W-1:0]            region_start;
	logic [LEN_W-1:0]              region_length;
	logic [START_W-1:0]            region_offset;
	logic [CNT_W-1:0]              region_count;
	logic                          enough_regions;
	logic                          too_long;
	logic                          last_result;

	threshold_region_finder_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.end_of_sequence(end_of_sequence),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.region_start   (region_start),
		.region_length  (region_length),
		.region_offset  (region_offset),
		.region_count   (region_count),
		.enough_regions (enough_regions),
		.too_long       (too_long),
		.last_result    (last_result)
	);

	// Handshakes seen at the last rising edge, used by the falling-edge processes.
	logic in_hs = 1'b0;
	logic out_hs = 1'b0;
	logic cfg_hs = 1'b0;

	sample_item_t sample_queue[$];
	result_t      expected_results[$];
	int           items_queued = 0;
	int           items_taken = 0;
	int           mismatches = 0;

	bit sender_idle = 1'b1;
	bit receiver_idle = 1'b1;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_requests = 0;
	int hold_seen = 0;

	// Shadow registers and sequence state of the region finder.
	cfg_t               regs;
	logic [POS_W-1:0]   seq_pos;
	logic               run_open;
	logic [START_W-1:0] run_start;
	logic [LEN_W-1:0]   run_len;
	logic [START_W-1:0] first_start;
	logic [CNT_W-1:0]   found;
	logic               overflow_seen;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_sequence();
		seq_pos       = '0;
		run_open      = 1'b0;
		run_start     = '0;
		run_len       = '0;
		first_start   = '0;
		found         = '0;
		overflow_seen = 1'b0;
	endfunction

	function automatic bit close_region(output result_t r);
		bit made;
		r = '0;
		made = run_open && run_len != 0 && run_len >= regs.min_run_length &&
			run_len <= regs.max_run_length;
		if (made) begin
			if (found == 0)
				first_start = run_start;
			if (found != COUNT_MAX)
				found++;
			r.kind   = KIND_REGION;
			r.start  = run_start;
			r.length = run_len;
			r.offset = run_start - first_start;
			r.count  = found;
		end
		run_open  = 1'b0;
		run_start = '0;
		run_len   = '0;
		return made;
	endfunction

	function automatic void apply_sample(logic signed [SAMPLE_BITS-1:0] value, logic eos);
		result_t res[2];
		result_t r;
		int      n;
		n = 0;
		if (seq_pos >= MAX_SEQ_LEN) begin
			overflow_seen = 1'b1;
		end else begin
			if ($signed(value) >= $signed(regs.level_threshold)) begin
				if (!run_open) begin
					run_open  = 1'b1;
					run_start = seq_pos[START_W-1:0];
					run_len   = LEN_W'(1);
				end else begin
					run_len++;
				end
			end else if (close_region(r)) begin
				res[n] = r;
				n++;
			end
			seq_pos++;
		end
		if (eos) begin
			if (close_region(r)) begin
				res[n] = r;
				n++;
			end
			r          = '0;
			r.kind     = KIND_VERDICT;
			r.count    = found;
			r.enough   = found >= regs.min_region_count;
			r.too_long = overflow_seen;
			res[n]     = r;
			n++;
			clear_sequence();
		end
		if (n > 0)
			res[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_results.push_back(res[i]);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	task automatic check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with nothing pending, kind", result_kind, 0);
			return;
		end
		want = expected_results.pop_front();
		if (result_kind !== want.kind)
			report_mismatch("result_kind", result_kind, want.kind);
		if (region_start !== want.start)
			report_mismatch("region_start", region_start, want.start);
		if (region_length !== want.length)
			report_mismatch("region_length", region_length, want.length);
		if (region_offset !== want.offset)
			report_mismatch("region_offset", region_offset, want.offset);
		if (region_count !== want.count)
			report_mismatch("region_count", region_count, want.count);
		if (enough_regions !== want.enough)
			report_mismatch("enough_regions", enough_regions, want.enough);
		if (too_long !== want.too_long)
			report_mismatch("too_long", too_long, want.too_long);
		if (last_result !== want.last)
			report_mismatch("last_result", last_result, want.last);
	endtask

	// Monitor: track register writes, predict on every input transaction, check outputs.
	always @(posedge clk) begin
		if (!arst_n) begin
			regs.level_threshold  = '0;
			regs.min_run_length   = 13'd1;
			regs.max_run_length   = 13'd4096;
			regs.min_region_count = '0;
			clear_sequence();
			in_hs  <= 1'b0;
			out_hs <= 1'b0;
			cfg_hs <= 1'b0;
		end else begin
			in_hs  <= in_valid && in_ready;
			out_hs <= out_valid && out_ready;
			cfg_hs <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LEVEL_THRESHOLD:  regs.level_threshold  = cfg_data;
					CFG_MIN_RUN_LENGTH:   regs.min_run_length   = cfg_data[LEN_W-1:0];
					CFG_MAX_RUN_LENGTH:   regs.max_run_length   = cfg_data[LEN_W-1:0];
					CFG_MIN_REGION_COUNT: regs.min_region_count = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				items_taken++;
				apply_sample(sample, end_of_sequence);
			end
			if (out_valid && out_ready)
				check_result();
		end
	end

	function automatic int pick_wait(bit enable);
		if (!enable)
			return 0;
		case ($urandom_range(0, 3))
			0, 1:    return 0;
			2:       return $urandom_range(1, 3);
			default: return $urandom_range(0, 16);
		endcase
	endfunction

	// Driver: hold the transaction until accepted, then wait out the drawn gap.
	always @(negedge clk) begin
		sample_item_t nxt;
		if (in_valid && in_hs)
			send_gap = pick_wait(sender_idle);
		if (!in_valid || in_hs) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (sample_queue.size() > 0) begin
				nxt = sample_queue.pop_front();
				sample          <= nxt.value;
				end_of_sequence <= nxt.eos;
				in_valid        <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: may stall after each result, or hold off for a long stretch on request.
	always @(negedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = 400;
		end
		if (out_hs)
			stall_left = pick_wait(receiver_idle);
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic void queue_sample(logic [SAMPLE_BITS-1:0] value, logic eos);
		sample_item_t it;
		it.value = value;
		it.eos   = eos;
		sample_queue.push_back(it);
		items_queued++;
	endfunction

	// Draw a value on the requested side of the threshold, often right at the boundary.
	function automatic logic [SAMPLE_BITS-1:0] pick_level(bit above);
		int t;
		int v;
		t = $signed(regs.level_threshold);
		if (above || t == -32768) begin
			if ($urandom_range(0, 3) == 0)
				v = t;
			else
				v = int'($urandom_range(65535, t + 32768)) - 32768;
		end else begin
			if ($urandom_range(0, 3) == 0)
				v = t - 1;
			else
				v = int'($urandom_range(t + 32767, 0)) - 32768;
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	function automatic int pick_run_length();
		int n;
		case ($urandom_range(0, 5))
			0:       n = int'(regs.min_run_length) - 1;
			1:       n = int'(regs.min_run_length);
			2:       n = int'(regs.max_run_length);
			3:       n = int'(regs.max_run_length) + 1;
			default: n = $urandom_range(1, 6);
		endcase
		if (n < 1)
			n = 1;
		if (n > 40)
			n = $urandom_range(1, 40);
		return n;
	endfunction

	// Alternate runs above and below the threshold, with a little noise mixed in.
	function automatic int queue_sequence();
		int runs;
		int len;
		int total;
		bit above;
		logic [SAMPLE_BITS-1:0] v;
		runs  = $urandom_range(1, 8);
		above = $urandom_range(0, 1);
		total = 0;
		for (int r = 0; r < runs; r++) begin
			len = above ? pick_run_length() : $urandom_range(1, 4);
			for (int i = 0; i < len; i++) begin
				v = ($urandom_range(0, 15) == 0) ? SAMPLE_BITS'($urandom) : pick_level(above);
				queue_sample(v, r == runs - 1 && i == len - 1);
				total++;
			end
			above = !above;
		end
		return total;
	endfunction

	function automatic void queue_sequences(int n);
		while (n > 0)
			n -= queue_sequence();
	endfunction

	function automatic void queue_long_sequence(int len, bit random_content);
		for (int i = 0; i < len; i++)
			queue_sample(random_content ? SAMPLE_BITS'($urandom) : pick_level(1'b1),
				i == len - 1);
	endfunction

	task automatic write_cfg(cfg_idx_t idx, int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CDATA_W-1:0];
		do @(negedge clk); while (!cfg_hs);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(int thr, int min_len, int max_len, int min_cnt);
		write_cfg(CFG_LEVEL_THRESHOLD, thr);
		write_cfg(CFG_MIN_RUN_LENGTH, min_len);
		write_cfg(CFG_MAX_RUN_LENGTH, max_len);
		write_cfg(CFG_MIN_REGION_COUNT, min_cnt);
	endtask

	// Wait until every sample is taken and every result checked, then let the pipe settle.
	task automatic wait_drain();
		do @(negedge clk);
		while (items_taken != items_queued || expected_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		int mn;
		int mx;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset configuration: extremes, value equal to threshold, two results on one sample.
		queue_sample(16'h7FFF, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h0000, 1'b0);
		queue_sample(16'hFFFF, 1'b1);
		queue_sample(16'hFF00, 1'b1);
		queue_sample(16'h0001, 1'b0);
		queue_sample(16'h0100, 1'b1);
		wait_drain();

		// Run lengths below, within and above the bounds; offset of a later region.
		write_all(16'h0100, 2, 3, 2);
		queue_sample(16'h0100, 1'b0);
		queue_sample(16'h0100, 1'b0);
		queue_sample(16'h00FF, 1'b0);
		for (int i = 0; i < 3; i++)
			queue_sample(16'h012C, 1'b0);
		queue_sample(16'hFFFB, 1'b0);
		for (int i = 0; i < 4; i++)
			queue_sample(16'h0190, 1'b0);
		queue_sample(16'hFFFF, 1'b1);
		queue_sample(16'h0100, 1'b0);
		queue_sample(16'h0000, 1'b1);
		wait_drain();

		// Minimum above maximum: nothing is reported.
		write_cfg(CFG_MIN_RUN_LENGTH, 5);
		write_cfg(CFG_MAX_RUN_LENGTH, 4);
		write_cfg(CFG_MIN_REGION_COUNT, 2048);
		for (int i = 0; i < 5; i++)
			queue_sample(16'h01F4, i == 4);
		wait_drain();

		// Lowest threshold: a run filling the whole sequence.
		write_all(-32768, 1, 4096, 0);
		queue_sequences(150);
		queue_long_sequence(40, 1'b0);
		wait_drain();

		// A run of exactly the only allowed length is reported, one longer is not.
		write_all(-32768, 40, 40, 2048);
		queue_long_sequence(40, 1'b0);
		queue_long_sequence(41, 1'b0);
		wait_drain();

		write_all(32767, 1, 2, 1);
		queue_sequences(150);
		queue_long_sequence(60, 1'b1);
		wait_drain();

		for (int p = 0; p < 10; p++) begin
			mn = $urandom_range(1, 8);
			mx = ($urandom_range(0, 5) == 0) ? mn - 1 : mn + $urandom_range(0, 12);
			if (mx < 1)
				mx = 1;
			write_all($urandom_range(0, 65535), mn, mx, $urandom_range(0, 5));
			sender_idle   = (p % 3 != 0);
			receiver_idle = (p % 2 != 0);
			if (p == 4) begin
				// Keep offering samples while the output side holds off.
				sender_idle = 1'b0;
				queue_sequences(200);
				hold_requests++;
			end
			queue_sequences(125);
			wait_drain();
		end

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
